@@ design/smrp_pkg.sv @@
// package for the signed mantissa round and pack unit
// holds the request and result types, round mode codes and bit scan helpers
// no dependencies
package smrp_pkg;

    localparam int MANT_WIDTH     = 64;
    localparam int EXP_WIDTH      = 32;
    localparam int MANT_OUT_WIDTH = 64;
    localparam int PREC_W         = 7;
    // shift plus stripped zeros is at most the mantissa width
    localparam int ADJ_W          = PREC_W + 1;
    localparam int MODE_W         = 3;

    typedef enum logic [MODE_W-1:0] {
        RND_FLOOR   = 3'd0,
        RND_CEIL    = 3'd1,
        RND_DOWN    = 3'd2,
        RND_UP      = 3'd3,
        RND_NEAREST = 3'd4
    } t_round_mode;

    typedef struct packed {
        logic signed [MANT_WIDTH-1:0] mantissa_in;
        logic signed [EXP_WIDTH-1:0]  exponent_in;
        logic [PREC_W-1:0]            target_precision;
        logic [MODE_W-1:0]            round_mode;
    } t_req;

    typedef struct packed {
        logic                         sign_out;
        logic [MANT_OUT_WIDTH-1:0]    mantissa_out;
        logic signed [EXP_WIDTH-1:0]  exponent_out;
        logic [PREC_W-1:0]            bit_count;
        logic                         exponent_overflow;
    } t_rsp;

    // rounded value handed from the rounding stage to the packing stage
    typedef struct packed {
        logic                         is_zero;
        logic                         neg;
        logic [MANT_WIDTH-1:0]        q;
        logic [PREC_W-1:0]            len;
        logic [PREC_W-1:0]            shift;
        logic signed [EXP_WIDTH-1:0]  exponent;
    } t_mid;

    function automatic logic [PREC_W-1:0] f_bit_length(input logic [MANT_WIDTH-1:0] v);
        logic [PREC_W-1:0] n;
        n = '0;
        for (int i = 0; i < MANT_WIDTH; i++) begin
            if (v[i]) begin
                n = PREC_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [PREC_W-1:0] f_trailing_zeros(input logic [MANT_WIDTH-1:0] v);
        logic [PREC_W-1:0] n;
        n = '0;
        for (int i = MANT_WIDTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = PREC_W'(i);
            end
        end
        return n;
    endfunction

endpackage

@@ design/smrp_round.sv @@
// rounding stage: magnitude, bit length, right shift by the excess and rounding
// depends on smrp_pkg
module smrp_round (
    input  smrp_pkg::t_req i_req,
    output smrp_pkg::t_mid o_mid
);
    import smrp_pkg::*;

    logic                  neg;
    logic [MANT_WIDTH-1:0] raw;
    logic [MANT_WIDTH-1:0] mag;
    logic [PREC_W-1:0]     len;
    logic [PREC_W-1:0]     prec;
    logic                  too_long;
    logic [PREC_W-1:0]     shift;
    logic [MANT_WIDTH-1:0] q_trunc;
    logic [MANT_WIDTH-1:0] sticky_mask;
    logic [MANT_WIDTH-1:0] below_round;
    logic                  round_bit;
    logic                  sticky;
    logic                  inexact;
    logic                  up;

    assign raw  = MANT_WIDTH'(i_req.mantissa_in);
    assign neg  = raw[MANT_WIDTH-1];
    assign mag  = neg ? (~raw + MANT_WIDTH'(1)) : raw;
    assign len  = f_bit_length(mag);
    assign prec = (i_req.target_precision == '0) ? len : i_req.target_precision;

    assign too_long = len > prec;
    assign shift    = too_long ? (len - prec) : '0;

    assign q_trunc     = mag >> shift;
    assign below_round = mag >> (shift - PREC_W'(1));
    // bits strictly below the round bit
    assign sticky_mask = ~({MANT_WIDTH{1'b1}} << (shift - PREC_W'(1)));
    assign round_bit   = below_round[0];
    assign sticky      = |(mag & sticky_mask);
    assign inexact     = round_bit | sticky;

    always_comb begin
        case (i_req.round_mode)
            RND_FLOOR: up = neg & inexact;
            RND_CEIL:  up = ~neg & inexact;
            RND_DOWN:  up = 1'b0;
            RND_UP:    up = inexact;
            default:   up = round_bit & (sticky | q_trunc[0]);
        endcase
    end

    always_comb begin
        o_mid.is_zero  = (mag == '0);
        o_mid.neg      = neg;
        o_mid.exponent = i_req.exponent_in;
        o_mid.shift    = shift;
        if (too_long) begin
            o_mid.q   = q_trunc + MANT_WIDTH'(up);
            o_mid.len = prec;
        end else begin
            o_mid.q   = mag;
            o_mid.len = len;
        end
    end

endmodule

@@ design/smrp_pack.sv @@
// packing stage: strips trailing zeros into the exponent and saturates it
// depends on smrp_pkg
module smrp_pack (
    input  smrp_pkg::t_mid i_mid,
    output smrp_pkg::t_rsp o_rsp
);
    import smrp_pkg::*;

    localparam logic signed [EXP_WIDTH-1:0] EXP_MAX = {1'b0, {(EXP_WIDTH-1){1'b1}}};

    logic [PREC_W-1:0]           zbits;
    logic [MANT_WIDTH-1:0]       q_odd;
    logic [PREC_W-1:0]           len_odd;
    logic [ADJ_W-1:0]            adj;
    logic signed [EXP_WIDTH:0]   exp_sum;
    logic                        ovf;

    assign zbits   = f_trailing_zeros(i_mid.q);
    assign q_odd   = i_mid.q >> zbits;
    // a carry out of rounding leaves a power of two that strips to one
    assign len_odd = (q_odd == MANT_WIDTH'(1)) ? PREC_W'(1) : (i_mid.len - zbits);

    assign adj     = ADJ_W'(i_mid.shift) + ADJ_W'(zbits);
    assign exp_sum = {i_mid.exponent[EXP_WIDTH-1], i_mid.exponent}
                   + signed'({1'b0, (EXP_WIDTH)'(adj)});
    assign ovf     = exp_sum[EXP_WIDTH] != exp_sum[EXP_WIDTH-1];

    always_comb begin
        if (i_mid.is_zero) begin
            o_rsp = '0;
        end else begin
            o_rsp.sign_out          = i_mid.neg;
            o_rsp.mantissa_out      = MANT_OUT_WIDTH'(q_odd);
            o_rsp.exponent_out      = ovf ? EXP_MAX : exp_sum[EXP_WIDTH-1:0];
            o_rsp.bit_count         = len_odd;
            o_rsp.exponent_overflow = ovf;
        end
    end

endmodule

@@ design/signed_mantissa_round_pack_unit.sv @@
// signed mantissa round and pack unit, top level
// an accepted request passes through the request register and then the result register
// throughput: one request per cycle while the receiver takes results; the rounding and
// packing logic sits between the request register and the result register
// reset: synchronous active-low i_rst_n clears both valid flags
// depends on smrp_pkg, smrp_round, smrp_pack
module signed_mantissa_round_pack_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  smrp_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output smrp_pkg::t_rsp  o_rsp
);
    import smrp_pkg::*;

    logic r_req_valid;
    t_req r_req;
    logic r_rsp_valid;
    t_rsp r_rsp;
    t_mid mid;
    t_rsp n_rsp;
    logic rsp_slot_free;

    // result slot frees when empty or being taken this cycle
    assign rsp_slot_free = ~r_rsp_valid | i_rsp_ready;
    assign o_req_ready   = ~r_req_valid | rsp_slot_free;

    smrp_round u_round (
        .i_req (r_req),
        .o_mid (mid)
    );

    smrp_pack u_pack (
        .i_mid (mid),
        .o_rsp (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (rsp_slot_free) begin
                r_rsp_valid <= r_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        if (r_req_valid && rsp_slot_free) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ verif/tb_top.sv @@
// testbench for signed_mantissa_round_pack_unit: directed corner requests,
// then random requests under several sender and receiver idling mixes
// depends on smrp_pkg and the unit; results are checked against a local predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smrp_pkg::*;

    localparam int     CYCLE_LIMIT = 200_000;
    localparam int     HOLD_CYCLES = 300;
    localparam longint EXP_LIMIT   = (longint'(1) <<< (EXP_WIDTH - 1)) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_data;

    t_req req_backlog[$];
    t_rsp rounded_results[$];
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    logic backpressure_on = 1'b0;
    logic hold_off = 1'b0;
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;

    signed_mantissa_round_pack_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_data),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected packing of one request
    function automatic t_rsp round_and_pack(input t_req r);
        t_rsp        res;
        logic        neg;
        logic        bump;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          len;
        int          prec;
        int          shift;
        int          zeros;
        longint      expo;
        res = '0;
        neg = r.mantissa_in[MANT_WIDTH-1];
        mag = neg ? ~r.mantissa_in + 64'd1 : r.mantissa_in;
        if (mag == 64'd0) begin
            return res;
        end
        len = 0;
        for (int i = 0; i < MANT_WIDTH; i++) begin
            if (mag[i]) begin
                len = i + 1;
            end
        end
        prec = r.target_precision;
        if (prec == 0) begin
            prec = len;
        end
        q = mag;
        shift = 0;
        if (len > prec) begin
            shift = len - prec;
            q = mag >> shift;
            rem = mag & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            case (r.round_mode)
                RND_FLOOR: bump = neg && rem != 64'd0;
                RND_CEIL:  bump = !neg && rem != 64'd0;
                RND_DOWN:  bump = 1'b0;
                RND_UP:    bump = rem != 64'd0;
                default:   bump = rem > half || (rem == half && q[0]);
            endcase
            if (bump) begin
                q = q + 64'd1;
            end
            len = prec;
        end
        zeros = 0;
        while (!q[0]) begin
            q = q >> 1;
            zeros++;
        end
        len = len - zeros;
        if (q == 64'd1) begin
            len = 1;
        end
        expo = r.exponent_in;
        if (expo > EXP_LIMIT - longint'(shift + zeros)) begin
            expo = EXP_LIMIT;
            res.exponent_overflow = 1'b1;
        end else begin
            expo = expo + shift + zeros;
        end
        res.sign_out = neg;
        res.mantissa_out = q;
        res.exponent_out = expo[EXP_WIDTH-1:0];
        res.bit_count = len[PREC_W-1:0];
        return res;
    endfunction

    task automatic add_req(input logic signed [63:0] m, input logic signed [31:0] e,
                           input logic [6:0] p, input logic [2:0] mode);
        t_req r;
        r.mantissa_in = m;
        r.exponent_in = e;
        r.target_precision = p;
        r.round_mode = mode;
        req_backlog.push_back(r);
    endtask

    function automatic t_req make_random_req();
        t_req        r;
        logic [63:0] v;
        int          pos;
        r.target_precision = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 65))
                                                     : 7'($urandom_range(64));
        r.round_mode = 3'($urandom_range(7));
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: ;
            1: v = 64'($urandom_range(255));
            2: v = v << $urandom_range(63);
            3: v = (64'd1 << $urandom_range(64, 1)) - 64'd1;
            4: begin
                // exact halfway remainder for the chosen precision
                pos = $urandom_range(61, 1);
                v = {2'b01, v[61:0]};
                v = ((v >> pos) << pos) | (64'd1 << (pos - 1));
                r.target_precision = 7'(63 - pos);
            end
            default: begin
                case ($urandom_range(3))
                    0: v = 64'h8000_0000_0000_0000;
                    1: v = 64'h7fff_ffff_ffff_ffff;
                    2: v = 64'd1;
                    default: v = '1;
                endcase
            end
        endcase
        if ($urandom_range(1) == 1) begin
            v = ~v + 64'd1;
        end
        r.mantissa_in = v;
        case ($urandom_range(3))
            0: r.exponent_in = 32'(EXP_LIMIT - $urandom_range(130));
            1: r.exponent_in = ($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: r.exponent_in = $urandom;
        endcase
        return r;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                rounded_results.push_back(round_and_pack(req_data));
            end
            if (!req_valid || req_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_valid <= 1'b1;
                    req_data <= req_backlog.pop_front();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (rounded_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = rounded_results.pop_front();
                    check_field("sign_out", 64'(want.sign_out), 64'(rsp_data.sign_out));
                    check_field("mantissa_out", want.mantissa_out, rsp_data.mantissa_out);
                    check_field("exponent_out", 64'(want.exponent_out),
                                64'(rsp_data.exponent_out));
                    check_field("bit_count", 64'(want.bit_count), 64'(rsp_data.bit_count));
                    check_field("exponent_overflow", 64'(want.exponent_overflow),
                                64'(rsp_data.exponent_overflow));
                end
            end
            rsp_ready <= !hold_off && $urandom_range(99) >= snk_stall_pct;
        end
    end

    // long receiver hold so the unit fills and stalls its input
    initial begin
        @(posedge clk iff backpressure_on);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        @(negedge clk);
        add_req(64'sd0, 32'sd5, 7'd10, RND_NEAREST);
        add_req(64'sh7fff_ffff_ffff_ffff, 32'sd0, 7'd0, RND_FLOOR);
        add_req(64'sh8000_0000_0000_0000, 32'sh8000_0000, 7'd0, RND_FLOOR);
        add_req(64'sh8000_0000_0000_0000, 32'sd0, 7'd1, RND_CEIL);
        add_req(-64'sd1, 32'sd0, 7'd64, RND_DOWN);
        // rounds up to a power of two and saturates the exponent
        add_req(64'sh7fff_ffff_ffff_ffff, 32'sh7fff_ffff, 7'd1, RND_UP);
        add_req(64'sd255, 32'sd0, 7'd4, RND_UP);
        add_req(-64'sd255, 32'sd0, 7'd4, RND_FLOOR);
        add_req(64'sd255, 32'sd0, 7'd4, RND_FLOOR);
        add_req(64'sd255, 32'sd0, 7'd4, RND_CEIL);
        add_req(-64'sd255, 32'sd0, 7'd4, RND_CEIL);
        add_req(-64'sd255, 32'sd0, 7'd4, RND_DOWN);
        // halfway cases, odd and even kept part, and one case just above halfway
        add_req(64'sh1c, 32'sd0, 7'd2, RND_NEAREST);
        add_req(-64'sh14, 32'sd0, 7'd2, RND_NEAREST);
        add_req(64'sh15, 32'sd0, 7'd2, RND_NEAREST);
        // unnamed mode codes behave as nearest
        for (int c = RND_NEAREST + 1; c < 8; c++) begin
            add_req(64'sh1c, 32'sd0, 7'd2, 3'(c));
        end
        add_req(64'sh7123_4567_89ab_cdef, 32'sd0, 7'd127, RND_UP);
        add_req(-64'sh0123_4567_89ab_cdef, 32'sd0, 7'd100, RND_UP);
        add_req(64'sh40, 32'sh8000_0000, 7'd0, RND_FLOOR);
        add_req(64'sd3, 32'sh7fff_ffff, 7'd0, RND_FLOOR);
        add_req(64'sd2, 32'sh7fff_fffe, 7'd0, RND_FLOOR);
        add_req(64'sd2, 32'sh7fff_ffff, 7'd0, RND_FLOOR);

        // steady, sender idle, receiver stall, both idle, long hold
        for (int ph = 0; ph < 5; ph++) begin
            while (req_backlog.size() != 0) @(negedge clk);
            src_idle_pct = (ph == 1) ? 85 : (ph == 3) ? 37 : 0;
            snk_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 37 : 0;
            backpressure_on = (ph == 4);
            for (int n = 0; n < ((ph == 4) ? 120 : 205); n++) begin
                req_backlog.push_back(make_random_req());
            end
        end
        while (req_backlog.size() != 0 || req_valid || rounded_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/smrp_pkg.sv
design/smrp_round.sv
design/smrp_pack.sv
design/signed_mantissa_round_pack_unit.sv
verif/tb_top.sv
